// ===== hw/rtl/ppac_pkg.sv =====
// ----------------------------------------------------------------------------
// Panel projected area package
// Shared types, field codes and fixed-point constants for the panel projected
// area and coefficient block.
// ----------------------------------------------------------------------------
package ppac_pkg;

  localparam int MAX_SURFACES = 64;
  localparam int SURF_IDX_W   = $clog2(MAX_SURFACES);
  localparam int COUNT_W      = 7;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] MODEL_DRAG = 2'd0;
  localparam logic [1:0] MODEL_RAD  = 2'd1;

  localparam logic [2:0] REG_USE_MODEL     = 3'd0;
  localparam logic [2:0] REG_SURFACE_COUNT = 3'd1;
  localparam logic [2:0] REG_REF_AREA      = 3'd2;
  localparam logic [2:0] REG_DEF_DRAG      = 3'd3;
  localparam logic [2:0] REG_DEF_RAD       = 3'd4;

  localparam logic [12:0] ONE_Q12      = 13'd4096;
  localparam logic [16:0] ONE_Q15      = 17'd32768;
  localparam logic [27:0] MOD_ONE      = 28'd134217728;
  localparam logic [29:0] RECIP_FIVE   = 30'd858993460;
  localparam int          DIV_STEPS    = 20;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         surface_index;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic [15:0]        surface_area;
    logic [15:0]        surface_drag;
    logic [15:0]        surface_rad;
    logic [15:0]        specularity;
    logic [15:0]        accommodation;
    logic [1:0]         model_sel;
    logic [15:0]        fallback_coeff;
  } in_t;

  typedef struct packed {
    logic [31:0] projected_area;
    logic [19:0] mean_coeff;
  } out_t;

endpackage

// ===== hw/rtl/ppac_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read of the same address per cycle, with registered read data.
// ----------------------------------------------------------------------------
module ppac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/panel_projected_area_coeff.sv =====
// ----------------------------------------------------------------------------
// Panel projected area and area-weighted coefficient
// Holds a table of flat panels and, per query, sums their projected areas and
// forms the area-weighted drag, radiation or reference coefficient.
// ----------------------------------------------------------------------------
// Usage: an input transfer with req_type load writes one panel entry and
// produces no result. A query transfer produces exactly one result transfer
// on the out_ channel. The cfg_ port writes the five registers; the user must
// only use it while no query is in flight, as the block does not enforce it.
// A query with the surface model off or no panels goes from its transfer to
// ST_FIN and then into the output register. Otherwise each panel runs through
// fetch, the x, y and z multiplies, cosine, projected area, area accumulate,
// weighting and weighted accumulate on the shared multiplier, with states D1
// to D7 added when the drag incidence modifier applies; then the restoring
// divider forms the quotient unless the summed area is zero, and ST_FIN loads
// the output register. in_stall stays high during reset and while a query is
// worked on; a new transfer is taken as soon as the result sits in the output
// register, even if the receiver is stalling. A finished result waits while
// out_stall holds the previous one. Synchronous reset clears the state, the
// configuration registers and out_valid, which empties the output. Panel
// entries have no reset and must be loaded before they are queried.
// ----------------------------------------------------------------------------
module panel_projected_area_coeff (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ppac_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ppac_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [15:0]      cfg_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_FETCH, ST_MX, ST_MY, ST_MZ, ST_CS, ST_PA, ST_ACC,
    ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6, ST_D7,
    ST_WS, ST_WACC, ST_DIVI, ST_DIV, ST_FIN
  } state_t;

  state_t state_r;

  logic                         use_model_r;
  logic [ppac_pkg::COUNT_W-1:0] surface_count_r;
  logic [15:0]                  ref_area_r;
  logic [15:0]                  def_drag_r;
  logic [15:0]                  def_rad_r;

  logic signed [15:0]           vx_r, vy_r, vz_r;
  logic [1:0]                   model_r;
  logic [15:0]                  refc_r;
  logic [ppac_pkg::COUNT_W-1:0] count_r;
  logic [ppac_pkg::COUNT_W-1:0] i_r;

  logic [57:0]        prod_r;
  logic signed [33:0] dot_r;
  logic [16:0]        c15_r;
  logic [32:0]        proj_r;
  logic [16:0]        coeff_r;
  logic [27:0]        mod_r;
  logic [26:0]        t_r;
  logic [38:0]        asum_r;
  logic [55:0]        wsum_r;
  logic [38:0]        rem_r;
  logic [4:0]         div_cnt_r;
  logic [31:0]        res_area_r;
  logic [19:0]        res_coeff_r;

  logic               out_valid_r;
  ppac_pkg::out_t     out_data_r;

  logic               in_accept;
  logic [ppac_pkg::COUNT_W-1:0] count_eff;

  logic [ppac_pkg::SURF_IDX_W-1:0] ram_addr;
  logic                            ram_we;
  logic [47:0] norm_rd, areac_rd;
  logic [31:0] mix_rd;

  logic signed [15:0] nx, ny, nz;
  logic [15:0]        p_area, p_drag, p_rad, p_spec, p_accom;
  logic [12:0]        sp_cl, ac_cl;
  logic [16:0]        inc;
  logic [16:0]        inc_plus;
  logic [15:0]        inc_minus;

  logic signed [33:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [64:0] mul_p;

  logic signed [33:0] dot_full;
  logic [33:0]        dot_neg;
  logic [29:0]        three_x;
  logic [39:0]        rem_try;
  logic               rem_ge;

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign count_eff = (surface_count_r > ppac_pkg::COUNT_W'(ppac_pkg::MAX_SURFACES)) ?
                     ppac_pkg::COUNT_W'(ppac_pkg::MAX_SURFACES) : surface_count_r;

  assign ram_we   = in_accept && (in_data.req_type == ppac_pkg::REQ_LOAD) &&
                    (int'(in_data.surface_index) < ppac_pkg::MAX_SURFACES);
  assign ram_addr = (state_r == ST_IDLE) ?
                    ppac_pkg::SURF_IDX_W'(in_data.surface_index) :
                    i_r[ppac_pkg::SURF_IDX_W-1:0];

  ppac_ram #(.WIDTH(48), .DEPTH(ppac_pkg::MAX_SURFACES)) u_normals (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.vec_x, in_data.vec_y, in_data.vec_z}),
    .rdata (norm_rd)
  );

  ppac_ram #(.WIDTH(48), .DEPTH(ppac_pkg::MAX_SURFACES)) u_area_coeffs (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.surface_area, in_data.surface_drag, in_data.surface_rad}),
    .rdata (areac_rd)
  );

  ppac_ram #(.WIDTH(32), .DEPTH(ppac_pkg::MAX_SURFACES)) u_surface_mix (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({in_data.specularity, in_data.accommodation}),
    .rdata (mix_rd)
  );

  assign nx      = norm_rd[47:32];
  assign ny      = norm_rd[31:16];
  assign nz      = norm_rd[15:0];
  assign p_area  = areac_rd[47:32];
  assign p_drag  = areac_rd[31:16];
  assign p_rad   = areac_rd[15:0];
  assign p_spec  = mix_rd[31:16];
  assign p_accom = mix_rd[15:0];

  assign sp_cl     = (p_spec > 16'(ppac_pkg::ONE_Q12)) ? ppac_pkg::ONE_Q12 : p_spec[12:0];
  assign ac_cl     = (p_accom > 16'(ppac_pkg::ONE_Q12)) ? ppac_pkg::ONE_Q12 : p_accom[12:0];
  assign inc       = (c15_r > ppac_pkg::ONE_Q15) ? ppac_pkg::ONE_Q15 : c15_r;
  assign inc_plus  = ppac_pkg::ONE_Q15 + inc;
  assign inc_minus = 16'(ppac_pkg::ONE_Q15 - inc);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MX: begin
        mul_a = 34'(nx);
        mul_b = 31'(vx_r);
      end
      ST_MY: begin
        mul_a = 34'(ny);
        mul_b = 31'(vy_r);
      end
      ST_MZ: begin
        mul_a = 34'(nz);
        mul_b = 31'(vz_r);
      end
      ST_PA: begin
        mul_a = {18'b0, p_area};
        mul_b = {14'b0, c15_r};
      end
      ST_D1: begin
        mul_a = {21'b0, ac_cl};
        mul_b = {14'b0, inc_plus};
      end
      ST_D2: begin
        mul_a = {21'b0, sp_cl};
        mul_b = {15'b0, inc_minus};
      end
      ST_D4: begin
        mul_a = {7'b0, t_r};
        mul_b = {1'b0, ppac_pkg::RECIP_FIVE};
      end
      ST_D6: begin
        mul_a = {6'b0, mod_r};
        mul_b = {14'b0, coeff_r};
      end
      ST_WS: begin
        mul_a = {1'b0, proj_r};
        mul_b = {14'b0, coeff_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign dot_full = dot_r + $signed(prod_r[33:0]);
  assign dot_neg  = 34'(-dot_full);
  assign three_x  = {2'b0, prod_r[27:0]} + {1'b0, prod_r[27:0], 1'b0};
  assign rem_try  = {rem_r, wsum_r[19]};
  assign rem_ge   = (rem_try >= {1'b0, asum_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      use_model_r     <= 1'b0;
      surface_count_r <= '0;
      ref_area_r      <= '0;
      def_drag_r      <= '0;
      def_rad_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          ppac_pkg::REG_USE_MODEL:     use_model_r     <= cfg_wdata[0];
          ppac_pkg::REG_SURFACE_COUNT: surface_count_r <= cfg_wdata[ppac_pkg::COUNT_W-1:0];
          ppac_pkg::REG_REF_AREA:      ref_area_r      <= cfg_wdata;
          ppac_pkg::REG_DEF_DRAG:      def_drag_r      <= cfg_wdata;
          ppac_pkg::REG_DEF_RAD:       def_rad_r       <= cfg_wdata;
          default: ;
        endcase
      end

      if ((state_r == ST_FIN) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      prod_r <= mul_p[57:0];

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept && (in_data.req_type == ppac_pkg::REQ_QUERY)) begin
            vx_r    <= in_data.vec_x;
            vy_r    <= in_data.vec_y;
            vz_r    <= in_data.vec_z;
            model_r <= in_data.model_sel;
            refc_r  <= in_data.fallback_coeff;
            count_r <= count_eff;
            i_r     <= '0;
            asum_r  <= '0;
            wsum_r  <= '0;
            if (!use_model_r || (count_eff == '0)) begin
              res_area_r  <= 32'(ref_area_r);
              res_coeff_r <= 20'(in_data.fallback_coeff);
              state_r     <= ST_FIN;
            end else begin
              state_r <= ST_FETCH;
            end
          end
        end
        ST_FETCH: state_r <= ST_MX;
        ST_MX:    state_r <= ST_MY;
        ST_MY: begin
          dot_r   <= $signed(prod_r[33:0]);
          state_r <= ST_MZ;
        end
        ST_MZ: begin
          dot_r   <= dot_full;
          state_r <= ST_CS;
        end
        ST_CS: begin
          c15_r   <= dot_full[33] ? dot_neg[31:15] : '0;
          state_r <= ST_PA;
        end
        ST_PA: state_r <= ST_ACC;
        ST_ACC: begin
          proj_r <= prod_r[32:0];
          asum_r <= asum_r + 39'(prod_r[32:0]);
          if (model_r == ppac_pkg::MODEL_DRAG) begin
            coeff_r <= 17'((p_drag != '0) ? p_drag : def_drag_r);
            state_r <= ((p_spec != '0) || (p_accom != '0)) ? ST_D1 : ST_WS;
          end else if (model_r == ppac_pkg::MODEL_RAD) begin
            coeff_r <= 17'((p_rad != '0) ? p_rad : def_rad_r);
            state_r <= ST_WS;
          end else begin
            coeff_r <= 17'(refc_r);
            state_r <= ST_WS;
          end
        end
        ST_D1: state_r <= ST_D2;
        ST_D2: begin
          mod_r   <= ppac_pkg::MOD_ONE + 28'(prod_r[28:2]);
          state_r <= ST_D3;
        end
        ST_D3: begin
          t_r     <= three_x[28:2];
          state_r <= ST_D4;
        end
        ST_D4: state_r <= ST_D5;
        ST_D5: begin
          mod_r   <= mod_r - 28'(prod_r[56:32]);
          state_r <= ST_D6;
        end
        ST_D6: state_r <= ST_D7;
        ST_D7: begin
          coeff_r <= prod_r[43:27];
          state_r <= ST_WS;
        end
        ST_WS: state_r <= ST_WACC;
        ST_WACC: begin
          wsum_r <= wsum_r + 56'(prod_r[49:0]);
          i_r    <= i_r + 1'b1;
          if ((i_r + 1'b1) == count_r) begin
            state_r <= ST_DIVI;
          end else begin
            state_r <= ST_FETCH;
          end
        end
        ST_DIVI: begin
          res_area_r <= 32'(asum_r[38:15]);
          if (asum_r == '0) begin
            res_coeff_r <= 20'(refc_r);
            state_r     <= ST_FIN;
          end else begin
            rem_r       <= 39'(wsum_r[55:20]);
            res_coeff_r <= '0;
            div_cnt_r   <= 5'(ppac_pkg::DIV_STEPS - 1);
            state_r     <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r       <= rem_ge ? 39'(rem_try - {1'b0, asum_r}) : rem_try[38:0];
          res_coeff_r <= {res_coeff_r[18:0], rem_ge};
          wsum_r      <= {wsum_r[54:0], 1'b0};
          div_cnt_r   <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.projected_area <= res_area_r;
            out_data_r.mean_coeff     <= res_coeff_r;
            state_r                   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
